// ----- src/flm_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and constants for the flow leak monitor.
// No dependencies; imported by every module of the block.
package flm_pkg;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_MIN_RATE     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_RATE     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_CAL_TENTHS   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_INTERVAL = 3'd4;

  localparam logic [7:0]  RST_MIN_RATE     = 8'd5;
  localparam logic [7:0]  RST_MAX_RATE     = 8'd40;
  localparam logic [5:0]  RST_THRESHOLD    = 6'd5;
  localparam logic [7:0]  RST_CAL_TENTHS   = 8'd45;
  localparam logic [15:0] RST_MIN_INTERVAL = 16'd1000;

  localparam int NUM_W  = 30;
  localparam int DEN_W  = 24;
  localparam int QUOT_W = 16;

  // Pulses times 1000 ms, times 10 for the tenths, times 256 for Q8.8.
  localparam logic [21:0] RATE_SCALE  = 22'd2560000;
  localparam logic [9:0]  ML_PER_L    = 10'd1000;
  // Division by 15 as a reciprocal multiply, exact for values below 64000.
  localparam logic [15:0] RECIP_15    = 16'd34953;
  localparam int          RECIP_SHIFT = 19;

  typedef struct packed {
    logic clear;
    logic push;
    logic flag;
  } win_ctrl_t;

endpackage

// ----- src/flm_divider.sv -----
`timescale 1ns / 1ps
// Restoring serial divider, one quotient bit per cycle, saturating result.
// Depends on flm_pkg for operand widths.
module flm_divider
  import flm_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [NUM_W-1:0]  num,
  input  logic [DEN_W-1:0]  den,
  output logic              busy,
  output logic              done,
  output logic [QUOT_W-1:0] quot
);

  logic [DEN_W-1:0]  rem_r, rem_nxt;
  logic [DEN_W-1:0]  den_r;
  logic [QUOT_W-1:0] quot_r;
  logic [4:0]        cnt_r;
  logic              busy_r, done_r, sat_r;
  logic [DEN_W:0]    shifted, diff;
  logic              ge;
  logic              ovf;

  // The quotient cannot fit when the numerator reaches the divisor shifted up by the quotient width.
  assign ovf = {{(DEN_W + QUOT_W - NUM_W){1'b0}}, num} >= {den, {QUOT_W{1'b0}}};

  assign shifted = {rem_r, quot_r[QUOT_W-1]};
  assign ge      = shifted >= {1'b0, den_r};
  assign diff    = shifted - {1'b0, den_r};
  assign rem_nxt = ge ? diff[DEN_W-1:0] : shifted[DEN_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= 5'd0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= 5'(QUOT_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 5'd1;
        if (cnt_r == 5'd1) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      sat_r  <= ovf;
      den_r  <= den;
      rem_r  <= DEN_W'(num[NUM_W-1:QUOT_W]);
      quot_r <= num[QUOT_W-1:0];
    end else if (busy_r) begin
      rem_r  <= rem_nxt;
      quot_r <= {quot_r[QUOT_W-2:0], ge};
    end
  end

  assign busy = busy_r;
  assign done = done_r;
  assign quot = sat_r ? {QUOT_W{1'b1}} : quot_r;

endmodule

// ----- src/flm_window.sv -----
`timescale 1ns / 1ps
// Sliding window of out-of-range flags with a fill level and a running set-flag count.
// Depends on flm_pkg for the window control struct.
module flm_window
  import flm_pkg::*;
#(
  parameter  int DEPTH = 10,
  localparam int CNT_W = $clog2(DEPTH + 1)
) (
  input  logic             clk,
  input  logic             rst_n,
  input  win_ctrl_t        ctrl,
  output logic [CNT_W-1:0] fill,
  output logic [CNT_W-1:0] count
);

  logic [DEPTH-1:0] flags_r, flags_nxt;
  logic [CNT_W-1:0] fill_r, fill_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  // The newest flag enters at bit 0; bits at or above the fill level are always zero.
  always_comb begin
    flags_nxt = flags_r;
    fill_nxt  = fill_r;
    count_nxt = count_r;
    if (ctrl.clear) begin
      flags_nxt = '0;
      fill_nxt  = '0;
      count_nxt = '0;
    end else if (ctrl.push) begin
      flags_nxt = DEPTH'({flags_r, ctrl.flag});
      fill_nxt  = (fill_r == CNT_W'(DEPTH)) ? fill_r : fill_r + 1'b1;
      count_nxt = count_r + CNT_W'(ctrl.flag) - CNT_W'(flags_r[DEPTH-1]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      flags_r <= '0;
      fill_r  <= '0;
      count_r <= '0;
    end else begin
      flags_r <= flags_nxt;
      fill_r  <= fill_nxt;
      count_r <= count_nxt;
    end
  end

  assign fill  = fill_r;
  assign count = count_r;

endmodule

// ----- src/flow_leak_monitor_unit.sv -----
`timescale 1ns / 1ps
// Flow leak monitor top level: accumulators, rate and total sequencer, leak latch.
// A measure word without a new rate passes the check, push and decide states before out_valid
// rises; one that computes a new rate also runs the 16-step serial divider and the total update.
// A reset-button word goes straight to the decide state. in_ready rises with out_valid, and a
// word waits in the decide state while a result is still held at the output.
// Synchronous active-low reset clears the control state and accumulators and loads the register defaults.
module flow_leak_monitor_unit
  import flm_pkg::*;
#(
  parameter int WINDOW_DEPTH = 10
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  in_op,
  input  logic [7:0]            in_pulses,
  input  logic [15:0]           in_elapsed_ms,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [15:0]           out_flow_rate,
  output logic [31:0]           out_total_ml,
  output logic                  out_leak_now,
  output logic                  out_valve_closed,
  output logic [5:0]            out_window_fill
);

  localparam int CNT_W = $clog2(WINDOW_DEPTH + 1);

  typedef enum logic [8:0] {
    S_IDLE     = 9'b000000001,
    S_CHECK    = 9'b000000010,
    S_DIVSTART = 9'b000000100,
    S_DIVWAIT  = 9'b000001000,
    S_TOTMUL   = 9'b000010000,
    S_TOTSCALE = 9'b000100000,
    S_TOTADD   = 9'b001000000,
    S_PUSH     = 9'b010000000,
    S_DECIDE   = 9'b100000000
  } state_t;

  state_t state_r, state_nxt;

  logic [7:0]  min_rate_r, max_rate_r, cal_r;
  logic [5:0]  threshold_r;
  logic [15:0] min_interval_r;

  logic        op_r;
  logic [7:0]  pulse_accum_r, prev_pulses_r;
  logic [15:0] time_accum_r;
  logic [16:0] time_sum;
  logic [15:0] rate_r;
  logic [31:0] total_r;
  logic        valve_r;
  logic [NUM_W-1:0] num_r;
  logic [DEN_W-1:0] den_r;
  logic [25:0] prod_r;
  logic [31:0] scaled;
  logic [12:0] inc_r;

  logic        out_valid_r;
  logic [15:0] out_rate_r;
  logic [31:0] out_total_r;
  logic        out_leak_r, out_valve_r;
  logic [5:0]  out_fill_r;

  logic              in_fire, slot_free, leak, range_flag;
  logic              div_start, div_busy, div_done;
  logic [QUOT_W-1:0] div_quot;
  win_ctrl_t         win_ctrl;
  logic [CNT_W-1:0]  win_fill, win_count;

  assign in_ready  = (state_r == S_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign slot_free = !out_valid_r || out_ready;
  assign time_sum  = {1'b0, time_accum_r} + {1'b0, in_elapsed_ms};
  assign range_flag = (rate_r < {min_rate_r, 8'h00}) || (rate_r > {max_rate_r, 8'h00});
  assign leak      = !op_r && (6'(win_count) >= threshold_r);
  assign div_start = (state_r == S_DIVSTART);
  assign scaled    = 32'(prod_r[25:10]) * 32'(RECIP_15);

  always_comb begin
    win_ctrl.clear = in_fire && in_op;
    win_ctrl.push  = (state_r == S_PUSH);
    win_ctrl.flag  = range_flag;
  end

  flm_divider u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (num_r),
    .den   (den_r),
    .busy  (div_busy),
    .done  (div_done),
    .quot  (div_quot)
  );

  flm_window #(
    .DEPTH (WINDOW_DEPTH)
  ) u_win (
    .clk   (clk),
    .rst_n (rst_n),
    .ctrl  (win_ctrl),
    .fill  (win_fill),
    .count (win_count)
  );

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          state_nxt = in_op ? S_DECIDE : S_CHECK;
        end
      end
      S_CHECK: begin
        state_nxt = (time_accum_r > min_interval_r) ? S_DIVSTART : S_PUSH;
      end
      S_DIVSTART: state_nxt = S_DIVWAIT;
      S_DIVWAIT: begin
        if (div_done) begin
          state_nxt = S_TOTMUL;
        end
      end
      S_TOTMUL:   state_nxt = S_TOTSCALE;
      S_TOTSCALE: state_nxt = S_TOTADD;
      S_TOTADD:   state_nxt = S_PUSH;
      S_PUSH:     state_nxt = S_DECIDE;
      S_DECIDE: begin
        if (slot_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= S_IDLE;
      min_rate_r     <= RST_MIN_RATE;
      max_rate_r     <= RST_MAX_RATE;
      threshold_r    <= RST_THRESHOLD;
      cal_r          <= RST_CAL_TENTHS;
      min_interval_r <= RST_MIN_INTERVAL;
      op_r           <= 1'b0;
      pulse_accum_r  <= '0;
      prev_pulses_r  <= '0;
      time_accum_r   <= '0;
      rate_r         <= '0;
      total_r        <= '0;
      valve_r        <= 1'b0;
      out_valid_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;

      if (cfg_we) begin
        unique case (cfg_index)
          CFG_MIN_RATE:     min_rate_r     <= cfg_wdata[7:0];
          CFG_MAX_RATE:     max_rate_r     <= cfg_wdata[7:0];
          CFG_THRESHOLD:    threshold_r    <= cfg_wdata[5:0];
          CFG_CAL_TENTHS:   cal_r          <= cfg_wdata[7:0];
          CFG_MIN_INTERVAL: min_interval_r <= cfg_wdata;
          default: ;
        endcase
      end

      if (in_fire) begin
        op_r <= in_op;
        if (in_op) begin
          valve_r <= 1'b0;
        end else begin
          pulse_accum_r <= pulse_accum_r + in_pulses;
          time_accum_r  <= time_sum[16] ? 16'hFFFF : time_sum[15:0];
        end
      end

      if (state_r == S_DIVWAIT && div_done) begin
        rate_r        <= div_quot;
        prev_pulses_r <= pulse_accum_r;
        pulse_accum_r <= '0;
        time_accum_r  <= '0;
      end

      if (state_r == S_TOTADD) begin
        total_r <= total_r + 32'(inc_r);
      end

      if (state_r == S_DECIDE && slot_free) begin
        out_valid_r <= 1'b1;
        valve_r     <= valve_r | leak;
      end else if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_CHECK) begin
      num_r <= NUM_W'(prev_pulses_r) * NUM_W'(RATE_SCALE);
      den_r <= DEN_W'(time_accum_r) * DEN_W'(cal_r);
    end
    if (state_r == S_TOTMUL) begin
      prod_r <= 26'(rate_r) * 26'(ML_PER_L);
    end
    if (state_r == S_TOTSCALE) begin
      inc_r <= 13'(scaled >> RECIP_SHIFT);
    end
    if (state_r == S_DECIDE && slot_free) begin
      out_rate_r  <= rate_r;
      out_total_r <= total_r;
      out_leak_r  <= leak;
      out_valve_r <= valve_r | leak;
      out_fill_r  <= 6'(win_fill);
    end
  end

  assign out_valid        = out_valid_r;
  assign out_flow_rate    = out_rate_r;
  assign out_total_ml     = out_total_r;
  assign out_leak_now     = out_leak_r;
  assign out_valve_closed = out_valve_r;
  assign out_window_fill  = out_fill_r;

  a_state_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot(state_r))
    else $error("sequencer state is not one-hot");

  a_leak_closes_valve: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_leak_now |-> out_valve_closed)
    else $error("leak reported without valve closure");

  a_fill_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    win_fill <= CNT_W'(WINDOW_DEPTH) && win_count <= win_fill)
    else $error("window fill or count out of bounds");

  a_reset_word_clears: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && in_op |=> win_fill == '0 && !valve_r)
    else $error("reset word did not clear window and valve");

  a_divider_started: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_DIVSTART |=> div_busy)
    else $error("divider did not start");

endmodule

// ----- tb/flow_leak_monitor_checker.sv -----
`timescale 1ns / 1ps
// Result checker for the flow leak monitor: follows register writes and accepted words,
// predicts each result word and compares it with what the block returns. Needs flm_pkg.
module flow_leak_monitor_checker
  import flm_pkg::*;
#(
  parameter int WINDOW_DEPTH = 10
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic                  in_valid,
  input  logic                  in_ready,
  input  logic                  in_op,
  input  logic [7:0]            in_pulses,
  input  logic [15:0]           in_elapsed_ms,
  input  logic                  out_valid,
  input  logic                  out_ready,
  input  logic [15:0]           out_flow_rate,
  input  logic [31:0]           out_total_ml,
  input  logic                  out_leak_now,
  input  logic                  out_valve_closed,
  input  logic [5:0]            out_window_fill,
  output int                    pending,
  output int                    mismatches
);

  typedef struct packed {
    logic [15:0] flow_rate;
    logic [31:0] total_ml;
    logic        leak_now;
    logic        valve_closed;
    logic [5:0]  window_fill;
  } reading_t;

  logic [7:0]  lo_rate;
  logic [7:0]  hi_rate;
  logic [5:0]  leak_threshold;
  logic [7:0]  calibration;
  logic [15:0] update_interval;

  logic        range_window [WINDOW_DEPTH];
  logic [5:0]  window_used;
  logic [15:0] rate_q88;
  logic [31:0] total_ml;
  logic [7:0]  last_pulses;
  logic [7:0]  pulse_sum;
  logic [15:0] time_sum;
  logic        valve_shut;

  reading_t    due_readings [$];
  int          fault_total;

  function automatic reading_t advance_meter(logic op, logic [7:0] pulses,
                                             logic [15:0] elapsed);
    logic [16:0] t_sum;
    logic [63:0] num;
    logic [63:0] den;
    logic [63:0] quo;
    logic [63:0] added_ml;
    logic        out_of_range;
    int          n_set;
    reading_t    r;
    r.leak_now = 1'b0;
    if (op) begin
      for (int i = 0; i < WINDOW_DEPTH; i++) range_window[i] = 1'b0;
      window_used = '0;
      valve_shut = 1'b0;
    end else begin
      pulse_sum = pulse_sum + pulses;
      t_sum = {1'b0, time_sum} + {1'b0, elapsed};
      time_sum = t_sum[16] ? 16'hFFFF : t_sum[15:0];
      if (time_sum > update_interval) begin
        num = {56'd0, last_pulses} * 64'd2560000;
        den = {48'd0, time_sum} * {56'd0, calibration};
        quo = (den == 64'd0) ? 64'hFFFF : num / den;
        if (quo > 64'hFFFF) quo = 64'hFFFF;
        rate_q88 = quo[15:0];
        added_ml = ({48'd0, rate_q88} * 64'd1000) / 64'd15360;
        total_ml = total_ml + added_ml[31:0];
        last_pulses = pulse_sum;
        pulse_sum = '0;
        time_sum = '0;
      end
      out_of_range = (rate_q88 < {lo_rate, 8'h00}) || (rate_q88 > {hi_rate, 8'h00});
      if (window_used >= WINDOW_DEPTH) begin
        for (int i = 0; i < WINDOW_DEPTH - 1; i++) range_window[i] = range_window[i+1];
        window_used = 6'(WINDOW_DEPTH - 1);
      end
      range_window[window_used] = out_of_range;
      window_used = window_used + 6'd1;
      n_set = 0;
      for (int i = 0; i < WINDOW_DEPTH; i++)
        if (i < window_used && range_window[i]) n_set++;
      if (n_set >= leak_threshold) begin
        r.leak_now = 1'b1;
        valve_shut = 1'b1;
      end
    end
    r.flow_rate = rate_q88;
    r.total_ml = total_ml;
    r.valve_closed = valve_shut;
    r.window_fill = window_used;
    return r;
  endfunction

  task automatic flag_mismatch(string field, logic [31:0] want, logic [31:0] got);
    $display("%0t: %s expected %0d, got %0d", $time, field, want, got);
    fault_total++;
  endtask

  always @(posedge clk) begin
    reading_t want;
    if (!rst_n) begin
      lo_rate = RST_MIN_RATE;
      hi_rate = RST_MAX_RATE;
      leak_threshold = RST_THRESHOLD;
      calibration = RST_CAL_TENTHS;
      update_interval = RST_MIN_INTERVAL;
      for (int i = 0; i < WINDOW_DEPTH; i++) range_window[i] = 1'b0;
      window_used = '0;
      rate_q88 = '0;
      total_ml = '0;
      last_pulses = '0;
      pulse_sum = '0;
      time_sum = '0;
      valve_shut = 1'b0;
      due_readings.delete();
      fault_total = 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_MIN_RATE:     lo_rate = cfg_wdata[7:0];
          CFG_MAX_RATE:     hi_rate = cfg_wdata[7:0];
          CFG_THRESHOLD:    leak_threshold = cfg_wdata[5:0];
          CFG_CAL_TENTHS:   calibration = cfg_wdata[7:0];
          CFG_MIN_INTERVAL: update_interval = cfg_wdata[15:0];
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        if (due_readings.size() == 0) begin
          $display("%0t: result word arrived with nothing expected", $time);
          fault_total++;
        end else begin
          want = due_readings.pop_front();
          if (out_flow_rate !== want.flow_rate)
            flag_mismatch("flow_rate", 32'(want.flow_rate), 32'(out_flow_rate));
          if (out_total_ml !== want.total_ml)
            flag_mismatch("total_ml", want.total_ml, out_total_ml);
          if (out_leak_now !== want.leak_now)
            flag_mismatch("leak_now", 32'(want.leak_now), 32'(out_leak_now));
          if (out_valve_closed !== want.valve_closed)
            flag_mismatch("valve_closed", 32'(want.valve_closed), 32'(out_valve_closed));
          if (out_window_fill !== want.window_fill)
            flag_mismatch("window_fill", 32'(want.window_fill), 32'(out_window_fill));
        end
      end
      if (in_valid && in_ready)
        due_readings.insert(due_readings.size(),
                            advance_meter(in_op, in_pulses, in_elapsed_ms));
    end
    pending <= due_readings.size();
    mismatches <= fault_total;
  end

endmodule

// ----- tb/flow_leak_monitor_unit_test.sv -----
`timescale 1ns / 1ps
// Top of the flow leak monitor testbench: clock, reset, register settings and word stimulus.
// Depends on flm_pkg, flow_leak_monitor_unit and flow_leak_monitor_checker.
module flow_leak_monitor_unit_test;
  import flm_pkg::*;

  localparam int CYCLE_LIMIT = 500000;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = CFG_MIN_RATE;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic                  in_op = 1'b0;
  logic [7:0]            in_pulses = '0;
  logic [15:0]           in_elapsed_ms = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [15:0]           out_flow_rate;
  logic [31:0]           out_total_ml;
  logic                  out_leak_now;
  logic                  out_valve_closed;
  logic [5:0]            out_window_fill;

  int                    pending;
  int                    mismatches;
  int                    cycle_count = 0;
  bit                    calm = 1'b0;
  logic [15:0]           cur_interval = RST_MIN_INTERVAL;

  flow_leak_monitor_unit dut (.*);

  flow_leak_monitor_checker u_check (.*);

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic bit take_break();
    return !calm && ($urandom_range(0, 99) < 32);
  endfunction

  always @(posedge clk) out_ready <= !take_break();

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("[flow_leak_monitor_unit] ERROR");
      $finish;
    end
  end

  task automatic send_word(logic op, logic [7:0] pulses, logic [15:0] elapsed);
    if (take_break()) begin
      in_valid <= 1'b0;
      do @(posedge clk); while (take_break());
    end
    in_valid <= 1'b1;
    in_op <= op;
    in_pulses <= pulses;
    in_elapsed_ms <= elapsed;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic configure(logic [7:0] lo, logic [7:0] hi, logic [5:0] thr,
                           logic [7:0] cal, logic [15:0] ival);
    logic [15:0] junk;
    junk = 16'($urandom);
    cfg_we <= 1'b1;
    cfg_index <= CFG_MIN_RATE;
    cfg_wdata <= {junk[15:8], lo};
    @(posedge clk);
    cfg_index <= CFG_MAX_RATE;
    cfg_wdata <= {junk[7:0], hi};
    @(posedge clk);
    cfg_index <= CFG_THRESHOLD;
    cfg_wdata <= {junk[15:6], thr};
    @(posedge clk);
    cfg_index <= CFG_CAL_TENTHS;
    cfg_wdata <= {~junk[15:8], cal};
    @(posedge clk);
    cfg_index <= CFG_MIN_INTERVAL;
    cfg_wdata <= ival;
    @(posedge clk);
    cfg_we <= 1'b0;
    cur_interval = ival;
  endtask

  task automatic random_word();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 5)
      send_word(1'b1, 8'($urandom), 16'($urandom));
    else if (pick < 15)
      send_word(1'b0, 8'($urandom), 16'($urandom));
    else
      send_word(1'b0, 8'($urandom_range(0, 80)),
                16'($urandom_range(0, cur_interval / 2 + 50)));
  endtask

  initial begin
    int n_words;
    logic [7:0] lo;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Power-on settings: ignored fields on a reset press, saturating time, the
    // exact interval boundary, a leak, a full window and the valve reopening.
    send_word(1'b1, 8'hFF, 16'hFFFF);
    send_word(1'b0, 8'h00, 16'h0000);
    send_word(1'b0, 8'hFF, 16'hFFFF);
    send_word(1'b0, 8'hFF, 16'hFFFF);
    send_word(1'b0, 8'd180, 16'd1001);
    send_word(1'b0, 8'd100, 16'd500);
    send_word(1'b0, 8'd100, 16'd500);
    send_word(1'b0, 8'd0, 16'd1);
    repeat (8) send_word(1'b0, 8'd90, 16'd501);
    send_word(1'b1, 8'h00, 16'h0000);
    send_word(1'b0, 8'd90, 16'd501);
    send_word(1'b0, 8'd90, 16'd501);
    send_word(1'b0, 8'd200, 16'd0);

    for (int phase = 0; phase < 9; phase++) begin
      settle();
      case (phase)
        0: configure(8'd5, 8'd40, 6'd5, 8'd45, 16'd1000);
        1: configure(8'd0, 8'd255, 6'd1, 8'd255, 16'd0);
        2: configure(8'd255, 8'd0, 6'd32, 8'd1, 16'hFFFF);
        3: configure(8'd10, 8'd30, 6'd0, 8'd0, 16'd500);
        4: configure(8'd0, 8'd20, 6'd63, 8'd255, 16'd1);
        default: begin
          lo = 8'($urandom_range(0, 30));
          configure(lo, 8'(32'(lo) + $urandom_range(0, 40)), 6'($urandom_range(1, 12)),
                    8'($urandom_range(20, 80)), 16'($urandom_range(200, 2000)));
        end
      endcase
      calm = (phase == 5);
      n_words = (phase < 5) ? 40 : 75;
      repeat (n_words) random_word();
    end
    calm = 1'b0;

    settle();
    repeat (50) @(posedge clk);
    if (mismatches == 0)
      $display("[flow_leak_monitor_unit] OK");
    else
      $display("[flow_leak_monitor_unit] ERROR");
    $finish;
  end

endmodule
